>>> rtl/mbld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbld_pkg
// Shared sizes, codes, types and address helpers of the bitmap line drawer.
// ----------------------------------------------------------------------------
package mbld_pkg;

  localparam int ROW_BYTES    = 10;
  localparam int SIDE_PIXELS  = ROW_BYTES * 8;
  localparam int BITMAP_BYTES = ROW_BYTES * ROW_BYTES * 8;
  localparam int ADDR_W       = $clog2(BITMAP_BYTES);

  localparam int MODE_W      = 2;
  localparam int COORD_W     = 7;
  localparam int INDEX_W     = 10;
  localparam int COLOR_W     = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int ERR_W       = COORD_W + 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COLOR_W-1:0] FG_RESET = 12'hFFF;
  localparam logic [COLOR_W-1:0] BG_RESET = 12'h000;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LINE,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [ADDR_W-1:0]  addr;
    logic               addr_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_EMIT,
    ST_ACK
  } state_t;

  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
    pixel_addr = ADDR_W'(int'(row) * ROW_BYTES + int'(col >> 3));
  endfunction

  function automatic logic pixel_on_map(input logic [COORD_W-1:0] col,
                                        input logic [COORD_W-1:0] row);
    pixel_on_map = (int'(col) < SIDE_PIXELS) && (int'(row) < SIDE_PIXELS);
  endfunction

endpackage
`default_nettype wire

>>> rtl/mbld_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbld_front
// Accepts input words, decodes the mode into an operation, checks the read
// index against the bitmap size and queues the command for the back end.
// ----------------------------------------------------------------------------
module mbld_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [mbld_pkg::MODE_W-1:0]      in_mode,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_start_x,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_start_y,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_end_x,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_end_y,
  input  wire  [mbld_pkg::INDEX_W-1:0]     in_byte_index,
  input  mbld_pkg::back_stat_t             back_stat,
  output logic                             q_valid,
  output mbld_pkg::cmd_t                   q_cmd,
  input  wire                              q_pop
);

  mbld_pkg::cmd_t                     q_mem_r [mbld_pkg::QUEUE_DEPTH];
  logic [mbld_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [mbld_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [mbld_pkg::QCNT_W-1:0]        count_r, count_nxt;
  mbld_pkg::cmd_t                     cmd_in;
  logic                               push;
  logic                               pop;

  always_comb begin
    cmd_in         = '0;
    case (in_mode)
      mbld_pkg::MODE_CLEAR: cmd_in.op = mbld_pkg::OP_CLEAR;
      mbld_pkg::MODE_LINE:  cmd_in.op = mbld_pkg::OP_LINE;
      mbld_pkg::MODE_READ:  cmd_in.op = mbld_pkg::OP_READ;
      default:              cmd_in.op = mbld_pkg::OP_NOP;
    endcase
    cmd_in.start_x = in_start_x;
    cmd_in.start_y = in_start_y;
    cmd_in.end_x   = in_end_x;
    cmd_in.end_y   = in_end_y;
    cmd_in.addr    = mbld_pkg::ADDR_W'(in_byte_index);
    // an index past the bitmap reads as a clear byte
    cmd_in.addr_ok = int'(in_byte_index) < mbld_pkg::BITMAP_BYTES;
  end

  assign in_ready = (count_r != mbld_pkg::QCNT_W'(mbld_pkg::QUEUE_DEPTH))
                    && !back_stat.init_busy;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + mbld_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + mbld_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + mbld_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - mbld_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mbld_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbld_back
// Bitmap memory and sequencer: clear sweep, Bresenham stepping with a
// read-modify-write per pixel, byte readout, color registers and the
// output word register.
// ----------------------------------------------------------------------------
module mbld_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_valid,
  input  mbld_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output mbld_pkg::back_stat_t             back_stat,
  input  wire                              cfg_wr,
  input  wire  [mbld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [mbld_pkg::COLOR_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mbld_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                             out_last
);

  logic [7:0] mem [mbld_pkg::BITMAP_BYTES];
  logic [7:0] rd_data_r;

  mbld_pkg::state_t state_r, state_nxt;

  logic [mbld_pkg::COORD_W-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [mbld_pkg::COORD_W-1:0]     xe_r, xe_nxt, ye_r, ye_nxt;
  logic                             x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic                             x_major_r, x_major_nxt;
  logic [mbld_pkg::DELTA_W-1:0]     dmaj_r, dmaj_nxt, dmin_r, dmin_nxt;
  logic signed [mbld_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [mbld_pkg::ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [mbld_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic                             addr_ok_r, addr_ok_nxt;
  logic [7:0]                       byte_r, byte_nxt;
  logic [2:0]                       bit_cnt_r, bit_cnt_nxt;
  logic [mbld_pkg::COLOR_W-1:0]     fg_r, bg_r;
  logic                             out_valid_r;
  logic [mbld_pkg::COLOR_W-1:0]     out_color_r, out_color_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_load;

  logic                             wr_en;
  logic [mbld_pkg::ADDR_W-1:0]      wr_addr;
  logic [7:0]                       wr_data;
  logic [mbld_pkg::ADDR_W-1:0]      rd_addr;

  // setup terms for a new line, taken from the queue head
  logic [mbld_pkg::COORD_W-1:0]     adx, ady;
  logic                             sx_neg, sy_neg, sx_major;
  logic [mbld_pkg::DELTA_W-1:0]     ddx, ddy;
  logic [mbld_pkg::ADDR_W-1:0]      pix_addr;
  logic                             pix_on;
  logic                             adj;
  logic                             line_done;
  logic                             clr_last;
  logic                             out_free;

  assign back_stat.init_busy = (state_r == mbld_pkg::ST_INIT);
  assign out_free  = !out_valid_r || out_ready;
  assign pix_addr  = mbld_pkg::pixel_addr(x_r, y_r);
  assign pix_on    = mbld_pkg::pixel_on_map(x_r, y_r);
  assign adj       = !err_r[mbld_pkg::ERR_W-1];
  assign line_done = x_major_r ? (x_r == xe_r) : (y_r == ye_r);
  assign clr_last  = (clr_cnt_r == mbld_pkg::ADDR_W'(mbld_pkg::BITMAP_BYTES - 1));

  always_comb begin
    sx_neg   = q_cmd.end_x < q_cmd.start_x;
    sy_neg   = q_cmd.end_y < q_cmd.start_y;
    adx      = sx_neg ? q_cmd.start_x - q_cmd.end_x : q_cmd.end_x - q_cmd.start_x;
    ady      = sy_neg ? q_cmd.start_y - q_cmd.end_y : q_cmd.end_y - q_cmd.start_y;
    ddx      = {adx, 1'b0};
    ddy      = {ady, 1'b0};
    sx_major = adx > ady;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    x_major_nxt   = x_major_r;
    dmaj_nxt      = dmaj_r;
    dmin_nxt      = dmin_r;
    err_nxt       = err_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    addr_ok_nxt   = addr_ok_r;
    byte_nxt      = byte_r;
    bit_cnt_nxt   = bit_cnt_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = pix_addr;
    wr_data       = rd_data_r | (8'b1 << x_r[2:0]);
    rd_addr       = pix_addr;
    out_load      = 1'b0;
    out_color_nxt = '0;
    out_last_nxt  = 1'b0;

    case (state_r)
      mbld_pkg::ST_INIT, mbld_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + mbld_pkg::ADDR_W'(1);
        if (clr_last) begin
          state_nxt = (state_r == mbld_pkg::ST_INIT) ? mbld_pkg::ST_IDLE
                                                      : mbld_pkg::ST_ACK;
        end
      end
      mbld_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            mbld_pkg::OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = mbld_pkg::ST_CLEAR;
            end
            mbld_pkg::OP_LINE: begin
              x_nxt       = q_cmd.start_x;
              y_nxt       = q_cmd.start_y;
              xe_nxt      = q_cmd.end_x;
              ye_nxt      = q_cmd.end_y;
              x_neg_nxt   = sx_neg;
              y_neg_nxt   = sy_neg;
              x_major_nxt = sx_major;
              dmaj_nxt    = sx_major ? ddx : ddy;
              dmin_nxt    = sx_major ? ddy : ddx;
              err_nxt     = sx_major
                ? mbld_pkg::ERR_W'(ddy) - mbld_pkg::ERR_W'(adx)
                : mbld_pkg::ERR_W'(ddx) - mbld_pkg::ERR_W'(ady);
              state_nxt   = mbld_pkg::ST_LINE_RD;
            end
            mbld_pkg::OP_READ: begin
              addr_nxt    = q_cmd.addr;
              addr_ok_nxt = q_cmd.addr_ok;
              state_nxt   = mbld_pkg::ST_READ_RD;
            end
            default: state_nxt = mbld_pkg::ST_ACK;
          endcase
        end
      end
      mbld_pkg::ST_LINE_RD: begin
        state_nxt = mbld_pkg::ST_LINE_WR;
      end
      mbld_pkg::ST_LINE_WR: begin
        // drop pixels off the bitmap, keep stepping
        wr_en = pix_on;
        if (line_done) begin
          state_nxt = mbld_pkg::ST_ACK;
        end else begin
          err_nxt = err_r + mbld_pkg::ERR_W'(dmin_r)
                    - (adj ? mbld_pkg::ERR_W'(dmaj_r) : mbld_pkg::ERR_W'(0));
          if (x_major_r || adj) begin
            x_nxt = x_neg_r ? x_r - mbld_pkg::COORD_W'(1) : x_r + mbld_pkg::COORD_W'(1);
          end
          if (!x_major_r || adj) begin
            y_nxt = y_neg_r ? y_r - mbld_pkg::COORD_W'(1) : y_r + mbld_pkg::COORD_W'(1);
          end
          state_nxt = mbld_pkg::ST_LINE_RD;
        end
      end
      mbld_pkg::ST_READ_RD: begin
        rd_addr   = addr_r;
        state_nxt = mbld_pkg::ST_READ_WAIT;
      end
      mbld_pkg::ST_READ_WAIT: begin
        byte_nxt    = addr_ok_r ? rd_data_r : 8'h00;
        bit_cnt_nxt = '0;
        state_nxt   = mbld_pkg::ST_EMIT;
      end
      mbld_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_color_nxt = byte_r[bit_cnt_r] ? fg_r : bg_r;
          out_last_nxt  = &bit_cnt_r;
          bit_cnt_nxt   = bit_cnt_r + 3'd1;
          if (&bit_cnt_r) begin
            state_nxt = mbld_pkg::ST_IDLE;
          end
        end
      end
      mbld_pkg::ST_ACK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = mbld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbld_pkg::ST_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      fg_r        <= mbld_pkg::FG_RESET;
      bg_r        <= mbld_pkg::BG_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_index)
          mbld_pkg::REG_FOREGROUND: fg_r <= cfg_data;
          mbld_pkg::REG_BACKGROUND: bg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    xe_r      <= xe_nxt;
    ye_r      <= ye_nxt;
    x_neg_r   <= x_neg_nxt;
    y_neg_r   <= y_neg_nxt;
    x_major_r <= x_major_nxt;
    dmaj_r    <= dmaj_nxt;
    dmin_r    <= dmin_nxt;
    err_r     <= err_nxt;
    addr_r    <= addr_nxt;
    addr_ok_r <= addr_ok_nxt;
    byte_r    <= byte_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    if (out_load) begin
      out_color_r <= out_color_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

>>> rtl/mono_bitmap_line_drawer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_bitmap_line_drawer
// 80x80 one-bit bitmap with clear, Bresenham line draw and byte readout.
// ----------------------------------------------------------------------------
// Timing: the bitmap is a single-port-write, registered-read memory of 800
// bytes, and every operation is paced by it. After reset the block sweeps the
// bitmap to zero, one byte a cycle, with in_ready low for the whole sweep
// (configuration writes are taken throughout). Each operation begins in the
// idle state, which takes its command from the queue. A clear then sweeps the
// whole bitmap and gives the acknowledge word. A line then handles each pixel
// step as a read, then an OR and write back, for max(|dx|,|dy|)+1 steps,
// and gives the acknowledge word. A byte read passes through the read and
// read-wait states after dispatch and then streams eight color words, one
// per cycle while out_ready is high. A two-entry command queue lets new words
// be accepted while an operation runs, and the output register lets the next
// operation start while a result word waits.
// ----------------------------------------------------------------------------
module mono_bitmap_line_drawer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [mbld_pkg::MODE_W-1:0]      in_mode,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_start_x,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_start_y,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_end_x,
  input  wire  [mbld_pkg::COORD_W-1:0]     in_end_y,
  input  wire  [mbld_pkg::INDEX_W-1:0]     in_byte_index,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mbld_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                             out_last,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [mbld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [mbld_pkg::COLOR_W-1:0]     cfg_data
);

  logic                 q_valid;
  logic                 q_pop;
  mbld_pkg::cmd_t       q_cmd;
  mbld_pkg::back_stat_t back_stat;

  assign cfg_ready = 1'b1;

  mbld_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_byte_index (in_byte_index),
    .back_stat     (back_stat),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  mbld_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .back_stat       (back_stat),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

>>> rtl/mbld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbld_checker
// Port-level checks of the bitmap line drawer, bound to the top level.
// ----------------------------------------------------------------------------
module mbld_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [mbld_pkg::COLOR_W-1:0]      out_pixel_color,
  input wire                              out_last
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_color) && $stable(out_last))
    else $error("result word changed while stalled");

  // the bitmap clear pass follows reset, so no word is taken right after it
  a_init_blocks_in: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted during the reset clear pass");

  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word presented right after reset");

  // no result word is present as reset is released, before any input is taken
  a_no_early_out: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid)
    else $error("result word without any accepted input");

endmodule

bind mono_bitmap_line_drawer mbld_checker u_mbld_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono bitmap line drawer: a queue-fed driver
// offers clear, line, read and spare-mode words, a shadow bitmap predicts
// every color word, and a monitor compares them in order under random
// back-pressure, one long output stall and several color settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [mbld_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 10000;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [mbld_pkg::MODE_W-1:0]  mode;
    logic [mbld_pkg::COORD_W-1:0] start_x;
    logic [mbld_pkg::COORD_W-1:0] start_y;
    logic [mbld_pkg::COORD_W-1:0] end_x;
    logic [mbld_pkg::COORD_W-1:0] end_y;
    logic [mbld_pkg::INDEX_W-1:0] byte_index;
  } draw_cmd_t;

  typedef struct packed {
    logic [mbld_pkg::COLOR_W-1:0] color;
    logic                         last;
  } color_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [mbld_pkg::MODE_W-1:0]      in_mode = '0;
  logic [mbld_pkg::COORD_W-1:0]     in_start_x = '0;
  logic [mbld_pkg::COORD_W-1:0]     in_start_y = '0;
  logic [mbld_pkg::COORD_W-1:0]     in_end_x = '0;
  logic [mbld_pkg::COORD_W-1:0]     in_end_y = '0;
  logic [mbld_pkg::INDEX_W-1:0]     in_byte_index = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [mbld_pkg::COLOR_W-1:0]     out_pixel_color;
  logic                             out_last;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mbld_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mbld_pkg::COLOR_W-1:0]     cfg_data = '0;

  // shadow state of the block
  logic [7:0]                   map_bits [mbld_pkg::BITMAP_BYTES];
  logic [mbld_pkg::COLOR_W-1:0] fg_shadow;
  logic [mbld_pkg::COLOR_W-1:0] bg_shadow;

  draw_cmd_t   pending[$];
  color_word_t colors_due[$];
  draw_cmd_t   on_offer;

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit recv_hold_req = 1'b0;
  int send_wait = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int lines_drawn = 0;
  int bytes_read = 0;
  int clears = 0;
  int cfg_writes = 0;

  mono_bitmap_line_drawer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_byte_index   (in_byte_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic void plot(int col, int row);
    if (col >= 0 && row >= 0 && col < mbld_pkg::SIDE_PIXELS && row < mbld_pkg::SIDE_PIXELS)
      map_bits[row * mbld_pkg::ROW_BYTES + col / 8][col % 8] = 1'b1;
  endfunction

  function automatic void trace_line(int x, int y, int xe, int ye);
    int ddx;
    int ddy;
    int sx;
    int sy;
    int err;
    ddx = xe - x;
    ddy = ye - y;
    sx = 1;
    sy = 1;
    if (ddx < 0) begin
      ddx = -ddx;
      sx = -1;
    end
    if (ddy < 0) begin
      ddy = -ddy;
      sy = -1;
    end
    ddx = ddx * 2;
    ddy = ddy * 2;
    plot(x, y);
    if (ddx > ddy) begin
      err = ddy - ddx / 2;
      while (x != xe) begin
        if (err >= 0) begin
          y = y + sy;
          err = err - ddx;
        end
        x = x + sx;
        err = err + ddy;
        plot(x, y);
      end
    end else begin
      err = ddx - ddy / 2;
      while (y != ye) begin
        if (err >= 0) begin
          x = x + sx;
          err = err - ddy;
        end
        y = y + sy;
        err = err + ddx;
        plot(x, y);
      end
    end
  endfunction

  function automatic void predict_words(draw_cmd_t c);
    logic [7:0] pix;
    case (c.mode)
      mbld_pkg::MODE_READ: begin
        pix = (int'(c.byte_index) < mbld_pkg::BITMAP_BYTES) ? map_bits[c.byte_index]
                                                             : 8'h00;
        for (int k = 0; k < 8; k++)
          colors_due.push_back('{pix[k] ? fg_shadow : bg_shadow, k == 7});
        bytes_read++;
      end
      mbld_pkg::MODE_CLEAR: begin
        foreach (map_bits[i]) map_bits[i] = 8'h00;
        colors_due.push_back('{'0, 1'b1});
        clears++;
      end
      mbld_pkg::MODE_LINE: begin
        trace_line(int'(c.start_x), int'(c.start_y), int'(c.end_x), int'(c.end_y));
        colors_due.push_back('{'0, 1'b1});
        lines_drawn++;
      end
      default: colors_due.push_back('{'0, 1'b1});
    endcase
  endfunction

  // ------------------------------------------------------------------ idling
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin : feed_words
    draw_cmd_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_words(on_offer);
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          on_offer = nxt;
          in_mode <= nxt.mode;
          in_start_x <= nxt.start_x;
          in_start_y <= nxt.start_y;
          in_end_x <= nxt.end_x;
          in_end_y <= nxt.end_y;
          in_byte_index <= nxt.byte_index;
          in_valid <= 1'b1;
          send_wait = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin : take_words
    color_word_t due;
    int roll;
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (colors_due.size() == 0) begin
        $error("unexpected word: pixel_color %0h last %0b", out_pixel_color, out_last);
        errors++;
      end else begin
        due = colors_due.pop_front();
        if (out_pixel_color !== due.color) begin
          $error("pixel_color: expected %0h, got %0h", due.color, out_pixel_color);
          errors++;
        end
        if (out_last !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, out_last);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_hold_req) begin
      // hold off long enough for the command queue to back up
      recv_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (recv_calm) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_left = (roll < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words still due",
               QUIET_LIMIT, colors_due.size());
      $display("mono_bitmap_line_drawer verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------- scenario
  task automatic push_cmd(input logic [mbld_pkg::MODE_W-1:0] mode, input int sx,
                          input int sy, input int ex, input int ey, input int idx);
    pending.push_back('{mode, mbld_pkg::COORD_W'(sx), mbld_pkg::COORD_W'(sy),
                        mbld_pkg::COORD_W'(ex), mbld_pkg::COORD_W'(ey),
                        mbld_pkg::INDEX_W'(idx)});
  endtask

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int roll;
    c.start_x = mbld_pkg::COORD_W'($urandom_range(0, 127));
    c.start_y = mbld_pkg::COORD_W'($urandom_range(0, 127));
    c.end_x = mbld_pkg::COORD_W'($urandom_range(0, 127));
    c.end_y = mbld_pkg::COORD_W'($urandom_range(0, 127));
    c.byte_index = mbld_pkg::INDEX_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    if (roll < 48) begin
      c.mode = mbld_pkg::MODE_LINE;
      // keep most lines on the map so later reads see set pixels
      if ($urandom_range(0, 3) != 0) begin
        c.start_x = mbld_pkg::COORD_W'($urandom_range(0, mbld_pkg::SIDE_PIXELS - 1));
        c.start_y = mbld_pkg::COORD_W'($urandom_range(0, mbld_pkg::SIDE_PIXELS - 1));
        c.end_x = mbld_pkg::COORD_W'($urandom_range(0, mbld_pkg::SIDE_PIXELS - 1));
        c.end_y = mbld_pkg::COORD_W'($urandom_range(0, mbld_pkg::SIDE_PIXELS - 1));
      end
    end else if (roll < 90) begin
      c.mode = mbld_pkg::MODE_READ;
      if ($urandom_range(0, 9) != 0)
        c.byte_index = mbld_pkg::INDEX_W'($urandom_range(0, mbld_pkg::BITMAP_BYTES - 1));
    end else if (roll < 95) begin
      c.mode = mbld_pkg::MODE_CLEAR;
    end else begin
      c.mode = MODE_SPARE;
    end
    return c;
  endfunction

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) pending.push_back(random_cmd());
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending.size() != 0 || in_valid || colors_due.size() != 0);
  endtask

  task automatic write_reg(input logic [mbld_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mbld_pkg::COLOR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mbld_pkg::REG_FOREGROUND)
      fg_shadow = value;
    else
      bg_shadow = value;
    cfg_writes++;
  endtask

  initial begin : scenario
    foreach (map_bits[i]) map_bits[i] = 8'h00;
    fg_shadow = mbld_pkg::FG_RESET;
    bg_shadow = mbld_pkg::BG_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under reset colors
    push_cmd(mbld_pkg::MODE_READ, 127, 127, 127, 127, 0);
    push_cmd(mbld_pkg::MODE_LINE, 0, 0, 79, 79, 1023);
    push_cmd(mbld_pkg::MODE_LINE, 79, 0, 0, 79, 0);
    push_cmd(mbld_pkg::MODE_LINE, 0, 5, 79, 5, 0);
    push_cmd(mbld_pkg::MODE_LINE, 5, 0, 5, 79, 0);
    push_cmd(mbld_pkg::MODE_LINE, 40, 40, 40, 40, 0);
    push_cmd(mbld_pkg::MODE_LINE, 10, 3, 73, 50, 0);
    push_cmd(mbld_pkg::MODE_LINE, 3, 10, 50, 73, 0);
    push_cmd(mbld_pkg::MODE_LINE, 127, 127, 0, 0, 0);
    push_cmd(mbld_pkg::MODE_LINE, 70, 75, 127, 90, 0);
    push_cmd(mbld_pkg::MODE_LINE, 127, 0, 127, 127, 0);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 0);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 799);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 55);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 405);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 800);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 1023);
    push_cmd(MODE_SPARE, 127, 127, 127, 127, 1023);
    push_cmd(mbld_pkg::MODE_CLEAR, 127, 127, 127, 127, 1023);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 0);
    push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, 799);
    wait_drained();

    // inverted extremes
    write_reg(mbld_pkg::REG_FOREGROUND, '0);
    write_reg(mbld_pkg::REG_BACKGROUND, '1);
    send_calm = 1'b1;
    push_random(60);
    wait_drained();

    // stall the output while reads keep coming
    send_calm = 1'b1;
    recv_hold_req = 1'b1;
    for (int i = 0; i < 4; i++)
      push_cmd(mbld_pkg::MODE_LINE, 0, i * 9, 79, 79 - i * 9, 0);
    for (int i = 0; i < 12; i++)
      push_cmd(mbld_pkg::MODE_READ, 0, 0, 0, 0, $urandom_range(0, 799));
    wait_drained();

    // random colors, idling on both sides
    send_calm = 1'b0;
    write_reg(mbld_pkg::REG_FOREGROUND, mbld_pkg::COLOR_W'($urandom_range(0, 4095)));
    write_reg(mbld_pkg::REG_BACKGROUND, mbld_pkg::COLOR_W'($urandom_range(0, 4095)));
    push_random(70);
    wait_drained();

    // reset-like colors, no idling at all
    write_reg(mbld_pkg::REG_FOREGROUND, '1);
    write_reg(mbld_pkg::REG_BACKGROUND, '0);
    send_calm = 1'b1;
    recv_calm = 1'b1;
    push_random(70);
    wait_drained();

    // alternating bit patterns
    write_reg(mbld_pkg::REG_FOREGROUND, 12'h555);
    write_reg(mbld_pkg::REG_BACKGROUND, 12'hAAA);
    send_calm = 1'b0;
    recv_calm = 1'b0;
    push_random(45);
    wait_drained();

    // catch stray words after the last one due
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d words in, %0d color words out, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("mix: %0d lines, %0d byte reads, %0d clears", lines_drawn, bytes_read, clears);
    if (errors == 0)
      $display("mono_bitmap_line_drawer verification clean");
    else
      $display("mono_bitmap_line_drawer verification failed");
    $finish;
  end

endmodule
